// ===== src/wsd_pkg.sv =====
`default_nettype none
package wsd_pkg;

    // Block limits.
    localparam int ANGLE_BITS     = 16;
    localparam int MAX_SPIN_TWICE = 8;
    localparam int NUM_COEFS      = 5;
    localparam int CORDIC_STEPS   = 24;
    localparam int POW_STEPS      = MAX_SPIN_TWICE;

    // Datapath widths.
    localparam int XY_W   = 34;
    localparam int Z_W    = 33;
    localparam int CS_W   = 32;
    localparam int COEF_W = 32;
    localparam int TERM_W = 40;
    localparam int SUM_W  = 43;
    localparam int ELEM_W = 18;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [XY_W-1:0] ONE_Q30     = XY_W'(64'sd1 << 30);

    typedef logic signed [CS_W-1:0]   cs_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic [3:0]               exp_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPIN   = 3'd0,
        CFG_PROJ1  = 3'd1,
        CFG_PROJ2  = 3'd2,
        CFG_COEF0  = 3'd3,
        CFG_COEF1  = 3'd4,
        CFG_COEF2  = 3'd5,
        CFG_COEF3  = 3'd6,
        CFG_COEF4  = 3'd7
    } cfg_idx_t;

    // Arctangent of 2^-i in Q.32 turn units.
    function automatic logic signed [Z_W-1:0] atan_val(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = Z_W'(536870912);
            1:  v = Z_W'(316933406);
            2:  v = Z_W'(167458907);
            3:  v = Z_W'(85004756);
            4:  v = Z_W'(42667331);
            5:  v = Z_W'(21354465);
            6:  v = Z_W'(10679838);
            7:  v = Z_W'(5340245);
            8:  v = Z_W'(2670163);
            9:  v = Z_W'(1335087);
            10: v = Z_W'(667544);
            11: v = Z_W'(333772);
            12: v = Z_W'(166886);
            13: v = Z_W'(83443);
            14: v = Z_W'(41722);
            15: v = Z_W'(20861);
            16: v = Z_W'(10430);
            17: v = Z_W'(5215);
            18: v = Z_W'(2608);
            19: v = Z_W'(1304);
            20: v = Z_W'(652);
            21: v = Z_W'(326);
            22: v = Z_W'(163);
            23: v = Z_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== src/wsd_cordic.sv =====
`default_nettype none
module wsd_cordic
    import wsd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output cs_t                        cos_half,
    output cs_t                        sin_half
);

    logic [31:0]            phase;
    logic [1:0]             quad;
    logic [31:0]            resid;
    logic signed [Z_W-1:0]  z0_reg;
    logic [1:0]             quad_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] x_reg [1:CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg [1:CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [1:CORDIC_STEPS];
    logic signed [XY_W-1:0] c_rot, s_rot, c_clamp, s_clamp;
    cs_t                    c_reg, s_reg;

    // Split the phase into a quadrant and a signed residual.
    always_comb
    begin
        phase = 32'(angle) << (32 - ANGLE_BITS);
        quad  = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - (32'(quad) << 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg      <= Z_W'(signed'(resid));
            quad_reg[0] <= quad;
        end
    end

    // One rotation per register stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [XY_W-1:0] xi, yi;
        logic signed [Z_W-1:0]  zi;
        if (i == 0)
        begin : g_first
            assign xi = CORDIC_GAIN;
            assign yi = '0;
            assign zi = z0_reg;
        end
        else
        begin : g_rest
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[Z_W-1])
                begin
                    x_reg[i+1] <= xi - (yi >>> i);
                    y_reg[i+1] <= yi + (xi >>> i);
                    z_reg[i+1] <= zi - atan_val(i);
                end
                else
                begin
                    x_reg[i+1] <= xi + (yi >>> i);
                    y_reg[i+1] <= yi - (xi >>> i);
                    z_reg[i+1] <= zi + atan_val(i);
                end
                quad_reg[i+1] <= quad_reg[i];
            end
        end
    end

    // Quadrant rotation and clamp to plus or minus one.
    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            2'd0:
            begin
                c_rot = x_reg[CORDIC_STEPS];
                s_rot = y_reg[CORDIC_STEPS];
            end
            2'd1:
            begin
                c_rot = -y_reg[CORDIC_STEPS];
                s_rot = x_reg[CORDIC_STEPS];
            end
            2'd2:
            begin
                c_rot = -x_reg[CORDIC_STEPS];
                s_rot = -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                c_rot = y_reg[CORDIC_STEPS];
                s_rot = -x_reg[CORDIC_STEPS];
            end
        endcase
        c_clamp = (c_rot > ONE_Q30) ? ONE_Q30 : ((c_rot < -ONE_Q30) ? -ONE_Q30 : c_rot);
        s_clamp = (s_rot > ONE_Q30) ? ONE_Q30 : ((s_rot < -ONE_Q30) ? -ONE_Q30 : s_rot);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= CS_W'(c_clamp);
            s_reg <= CS_W'(s_clamp);
        end
    end

    assign cos_half = c_reg;
    assign sin_half = s_reg;

endmodule
`default_nettype wire

// ===== src/wsd_power.sv =====
`default_nettype none
module wsd_power
    import wsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire cs_t  cos_half,
    input  wire cs_t  sin_half,
    input  wire exp_t exp_cos,
    input  wire exp_t exp_sin,
    output cs_t       power
);

    cs_t p_reg [1:POW_STEPS];
    cs_t c_reg [1:POW_STEPS-1];
    cs_t s_reg [1:POW_STEPS-1];

    // Stages below exp_cos multiply by cosine, the next exp_sin by sine, the rest pass through.
    for (genvar k = 0; k < POW_STEPS; k++)
    begin : g_mul
        cs_t                    pi, ci, si, mi;
        logic signed [63:0]     prod;
        logic signed [63:0]     rnd;
        logic                   use_c, use_s;
        if (k == 0)
        begin : g_first
            assign pi = CS_W'(ONE_Q30);
            assign ci = cos_half;
            assign si = sin_half;
        end
        else
        begin : g_rest
            assign pi = p_reg[k];
            assign ci = c_reg[k];
            assign si = s_reg[k];
        end

        always_comb
        begin
            use_c = 5'(k) < 5'(exp_cos);
            use_s = 5'(k) < (5'(exp_cos) + 5'(exp_sin));
            mi    = use_c ? ci : si;
            prod  = 64'(pi) * 64'(mi);
            rnd   = (prod + 64'sd536870912) >>> 30;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                p_reg[k+1] <= use_s ? CS_W'(rnd) : pi;
        end

        // Cosine and sine travel along to the stages that still need them.
        if (k < POW_STEPS - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    c_reg[k+1] <= ci;
                    s_reg[k+1] <= si;
                end
            end
        end
    end

    assign power = p_reg[POW_STEPS];

endmodule
`default_nettype wire

// ===== src/wigner_small_d_evaluator.sv =====
`default_nettype none
// Wigner small-d evaluator.
// Input channel: angle with in_valid/in_ready; the half angle is one full turn
// over the 16-bit range. Output channel: element (signed Q2.16, saturated to
// plus or minus one) with out_valid/out_ready. One result per transaction.
// Configuration: cfg_we/cfg_index/cfg_data write spin_twice, proj_first_twice,
// proj_second_twice and coef_0..coef_4 (Q8.24) at indexes 0 to 7. Write only
// while no transaction is in flight.
// The pipeline has one phase stage, 24 CORDIC rotation stages, one
// quadrant stage, eight power-multiply stages, then term, sum and output
// register. Throughput is one transaction per cycle while the receiver does
// not stall, set by the fully pipelined CORDIC and multiplier lanes.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads spin zero, projections zero,
// coef_0 = 1.0 and the other coefficients zero.
module wigner_small_d_evaluator
    import wsd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [ANGLE_BITS-1:0]  angle,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [ELEM_W-1:0]    element,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COEF_W-1:0]      cfg_data
);

    localparam int LAT = 1 + CORDIC_STEPS + 1 + POW_STEPS + 3;

    logic [3:0]          spin_reg;
    logic signed [4:0]   proj1_reg;
    logic [3:0]          proj2_reg;
    coef_t               coef_reg [0:NUM_COEFS-1];
    logic [LAT-1:0]      vld_reg;
    logic                en;
    cs_t                 cos_half, sin_half;
    cs_t                 power [0:NUM_COEFS-1];
    term_t               term_reg [0:NUM_COEFS-1];
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [ELEM_W-1:0] element_reg;
    logic signed [ELEM_W-1:0] element_next;
    logic signed [SUM_W-1:0]  scaled;
    logic signed [6:0]   bigj, m1, m2, abs_m1, half_diff, n_terms;
    logic                ok;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_reg  <= '0;
            proj1_reg <= '0;
            proj2_reg <= '0;
            coef_reg[0] <= COEF_W'(32'sd16777216);
            for (int i = 1; i < NUM_COEFS; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SPIN:  spin_reg  <= cfg_data[3:0];
                CFG_PROJ1: proj1_reg <= cfg_data[4:0];
                CFG_PROJ2: proj2_reg <= cfg_data[3:0];
                CFG_COEF0: coef_reg[0] <= cfg_data;
                CFG_COEF1: coef_reg[1] <= cfg_data;
                CFG_COEF2: coef_reg[2] <= cfg_data;
                CFG_COEF3: coef_reg[3] <= cfg_data;
                CFG_COEF4: coef_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Spin set checks and series shape.
    always_comb
    begin
        bigj      = 7'(spin_reg);
        m1        = 7'(proj1_reg);
        m2        = 7'(proj2_reg);
        abs_m1    = m1[6] ? -m1 : m1;
        ok        = (bigj <= 7'(MAX_SPIN_TWICE)) && (m2 <= bigj) && (abs_m1 <= m2) &&
                    !(bigj[0] ^ m2[0]) && !(m2[0] ^ m1[0]);
        half_diff = (m2 - m1) >>> 1;
        n_terms   = ((bigj - m2) >>> 1) + 7'sd1;
    end

    // Global pipeline enable: everything holds while a result is stalled.
    assign en       = !(vld_reg[LAT-1] && !out_ready);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    wsd_cordic u_cordic (
        .clk      (clk),
        .en       (en),
        .angle    (angle),
        .cos_half (cos_half),
        .sin_half (sin_half)
    );

    // One power lane per series term.
    for (genvar t = 0; t < NUM_COEFS; t++)
    begin : g_lane
        exp_t exp_c, exp_s;
        logic signed [6:0] ec, es;
        logic active;
        logic signed [63:0] prod;

        always_comb
        begin
            active = ok && (7'(t) < n_terms);
            ec     = bigj - half_diff - 7'(2 * t);
            es     = half_diff + 7'(2 * t);
            exp_c  = active ? 4'(ec) : '0;
            exp_s  = active ? 4'(es) : '0;
        end

        wsd_power u_power (
            .clk      (clk),
            .en       (en),
            .cos_half (cos_half),
            .sin_half (sin_half),
            .exp_cos  (exp_c),
            .exp_sin  (exp_s),
            .power    (power[t])
        );

        // Weighted term, dropped when the lane is beyond the series or the spin set is invalid.
        assign prod = 64'(coef_reg[t]) * 64'(power[t]);

        always_ff @(posedge clk)
        begin
            if (en)
                term_reg[t] <= active ? TERM_W'((prod + 64'sd8388608) >>> 24) : '0;
        end
    end

    // Sum of terms.
    always_comb
    begin
        sum_next = '0;
        for (int t = 0; t < NUM_COEFS; t++)
            sum_next = sum_next + SUM_W'(term_reg[t]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= sum_next;
    end

    // Round to Q.16 and saturate to plus or minus one.
    always_comb
    begin
        scaled = (sum_reg + SUM_W'(8192)) >>> 14;
        if (scaled > SUM_W'(65536))
            element_next = ELEM_W'(65536);
        else if (scaled < -SUM_W'(65536))
            element_next = -ELEM_W'(65536);
        else
            element_next = ELEM_W'(scaled);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            element_reg <= element_next;
    end

    assign out_valid = vld_reg[LAT-1];
    assign element   = element_reg;

    // A stalled result freezes the whole pipeline.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(vld_reg) && $stable(element_reg)))
        else $error("pipeline moved during output stall");

    // An accepted transaction enters the first valid stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted transaction lost at pipeline entry");

    // A delivered element is always inside plus or minus one.
    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((element <= 18'sd65536) && (element >= -18'sd65536)))
        else $error("element outside saturation range");

endmodule
`default_nettype wire

// ===== dv/wigner_small_d_evaluator_tb.sv =====
`timescale 1ns / 100ps
module wigner_small_d_evaluator_tb;
    import wsd_pkg::*;

    localparam int PIPE_LATENCY = 37;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [ANGLE_BITS-1:0]     angle;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [ELEM_W-1:0]  element;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [COEF_W-1:0]         cfg_data;

    // Shadow copy of the configuration registers.
    logic [3:0]                spin_sh;
    logic signed [4:0]         proj1_sh;
    logic [3:0]                proj2_sh;
    logic signed [COEF_W-1:0]  coef_sh [NUM_COEFS];

    logic signed [ELEM_W-1:0]  pending_elements [$];
    int                        errors;
    int                        send_idle_pct;
    int                        recv_stall_pct;

    wigner_small_d_evaluator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .element   (element),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Arctangent table of the rotation steps.
    function automatic longint rot_atan(input int i);
        longint tab [CORDIC_STEPS] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215,
            2608, 1304, 652, 326, 163, 81};
        return tab[i];
    endfunction

    function automatic longint round_q30(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Expected d-function value for one angle under the shadow configuration.
    function automatic logic signed [ELEM_W-1:0] predict_element(
        input logic [ANGLE_BITS-1:0] ang);
        int         bigj;
        int         m1;
        int         m2;
        int         abs_m1;
        int         half_diff;
        int         n_terms;
        int         ec;
        int         es;
        logic [31:0] ph;
        logic [31:0] rr;
        logic [1:0]  quad;
        int         rr_s;
        longint     x;
        longint     y;
        longint     z;
        longint     nx;
        longint     cq;
        longint     sq;
        longint     p;
        longint     acc;
        longint     res;
        bigj = spin_sh;
        m1 = proj1_sh;
        m2 = proj2_sh;
        abs_m1 = (m1 < 0) ? -m1 : m1;
        if (!(bigj <= MAX_SPIN_TWICE && m2 <= bigj && abs_m1 <= m2 &&
              ((bigj - m2) & 1) == 0 && ((m2 - m1) & 1) == 0))
            return '0;

        // Half-angle cosine and sine by rotation.
        ph = {ang, {(32 - ANGLE_BITS){1'b0}}};
        quad = 2'((ph + 32'h2000_0000) >> 30);
        rr = ph - ({30'd0, quad} << 30);
        rr_s = int'(rr);
        z = rr_s;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - rot_atan(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + rot_atan(i);
            end
            x = nx;
        end
        case (quad)
            2'd0:    begin cq = x;  sq = y;  end
            2'd1:    begin cq = -y; sq = x;  end
            2'd2:    begin cq = -x; sq = -y; end
            default: begin cq = y;  sq = -x; end
        endcase
        if (cq > (64'sd1 <<< 30)) cq = 64'sd1 <<< 30;
        if (cq < -(64'sd1 <<< 30)) cq = -(64'sd1 <<< 30);
        if (sq > (64'sd1 <<< 30)) sq = 64'sd1 <<< 30;
        if (sq < -(64'sd1 <<< 30)) sq = -(64'sd1 <<< 30);

        // Weighted sum of the power terms.
        half_diff = (m2 - m1) / 2;
        n_terms = (bigj - m2) / 2 + 1;
        acc = 0;
        for (int t = 0; t < n_terms && t < NUM_COEFS; t++)
        begin
            ec = bigj - half_diff - 2 * t;
            es = half_diff + 2 * t;
            p = 64'sd1 <<< 30;
            for (int e = 0; e < ec; e++)
                p = round_q30(p, cq);
            for (int e = 0; e < es; e++)
                p = round_q30(p, sq);
            acc = acc + ((longint'(coef_sh[t]) * p + (64'sd1 <<< 23)) >>> 24);
        end
        res = (acc + (64'sd1 <<< 13)) >>> 14;
        if (res > 65536) res = 65536;
        if (res < -65536) res = -65536;
        return ELEM_W'(res);
    endfunction

    // Drive one configuration register and mirror it in the shadow copy.
    task automatic write_reg(input cfg_idx_t idx, input logic [COEF_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SPIN:  spin_sh = data[3:0];
            CFG_PROJ1: proj1_sh = data[4:0];
            CFG_PROJ2: proj2_sh = data[3:0];
            default:   coef_sh[int'(idx) - int'(CFG_COEF0)] = data;
        endcase
        @(posedge clk);
    endtask

    // Write a full spin set and coefficient set; upper bits of the narrow
    // registers carry noise that the block must ignore.
    task automatic load_config(input logic [3:0] j, input logic [4:0] m1,
                               input logic [3:0] m2, input logic [31:0] c0,
                               input logic [31:0] c1, input logic [31:0] c2,
                               input logic [31:0] c3, input logic [31:0] c4);
        write_reg(CFG_SPIN, {28'($urandom), j});
        write_reg(CFG_PROJ1, {27'($urandom), m1});
        write_reg(CFG_PROJ2, {28'($urandom), m2});
        write_reg(CFG_COEF0, c0);
        write_reg(CFG_COEF1, c1);
        write_reg(CFG_COEF2, c2);
        write_reg(CFG_COEF3, c3);
        write_reg(CFG_COEF4, c4);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Send one angle transaction; the expectation is queued on acceptance.
    task automatic send_angle(input logic [ANGLE_BITS-1:0] a);
        logic accepted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle <= a;
        do
        begin
            @(negedge clk);
            accepted = in_ready;
            @(posedge clk);
        end while (!accepted);
        pending_elements.push_back(predict_element(a));
    endtask

    // Wait until every expected result has arrived, then let the pipe settle.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_elements.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coef;
        if ($urandom_range(9) < 2)
            return $urandom;
        return 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
    endfunction

    task automatic load_random_config;
        logic [3:0] j;
        logic [3:0] m2;
        int         m1;
        if ($urandom_range(9) < 2)
        begin
            load_config(4'($urandom), 5'($urandom), 4'($urandom), rand_coef(),
                        rand_coef(), rand_coef(), rand_coef(), rand_coef());
        end
        else
        begin
            j = 4'($urandom_range(MAX_SPIN_TWICE));
            m2 = 4'($urandom_range(j));
            // An odd gap means M2 is below J, so one step up stays legal.
            if (((j - m2) & 4'd1) != 4'd0)
                m2 = m2 + 4'd1;
            m1 = int'($urandom_range(2 * m2)) - int'(m2);
            if (((m2 - m1) & 1) != 0)
                m1 = (m1 > 0) ? m1 - 1 : m1 + 1;
            load_config(j, 5'(m1), m2, rand_coef(), rand_coef(), rand_coef(),
                        rand_coef(), rand_coef());
        end
    endtask

    task automatic test_directed;
        logic [ANGLE_BITS-1:0] edge_angles [6] = '{16'h0000, 16'h2000, 16'h4000,
                                                   16'h8000, 16'hC000, 16'hFFFF};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Reset configuration: J = 0 gives coef_0 for every angle.
        foreach (edge_angles[k]) send_angle(edge_angles[k]);
        drain();
        // Highest spin with negative first projection and extreme coefficients.
        load_config(4'd8, -5'sd8, 4'd8, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF);
        foreach (edge_angles[k]) send_angle(edge_angles[k]);
        drain();
        // All five terms in use, large negative weights to hit saturation.
        load_config(4'd8, 5'd0, 4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000);
        foreach (edge_angles[k]) send_angle(edge_angles[k]);
        drain();
        // Invalid spin sets: spin too large, M2 above J, |M1| above M2, parity.
        load_config(4'd15, 5'd1, 4'd1, 32'h0100_0000, 0, 0, 0, 0);
        send_angle(16'h1234);
        drain();
        load_config(4'd2, 5'd0, 4'd4, 32'h0100_0000, 0, 0, 0, 0);
        send_angle(16'h1234);
        drain();
        load_config(4'd4, -5'sd4, 4'd2, 32'h0100_0000, 0, 0, 0, 0);
        send_angle(16'h1234);
        drain();
        load_config(4'd3, 5'd0, 4'd1, 32'h0100_0000, 0, 0, 0, 0);
        send_angle(16'h1234);
        drain();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int s = 0; s < 4; s++)
        begin
            load_random_config();
            for (int k = 0; k < n / 4; k++)
                send_angle(16'($urandom));
            drain();
        end
    endtask

    // Receiver stall pattern.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each output transaction with the oldest expectation.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_elements.size() == 0)
            begin
                $error("element: unexpected result %0d", element);
                errors++;
            end
            else
            begin
                if (element !== pending_elements[0])
                begin
                    $error("element: expected %0d, actual %0d",
                           pending_elements[0], element);
                    errors++;
                end
                void'(pending_elements.pop_front());
            end
        end
    end

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        angle = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SPIN;
        cfg_data = '0;
        spin_sh = '0;
        proj1_sh = '0;
        proj2_sh = '0;
        coef_sh[0] = 32'sh0100_0000;
        for (int i = 1; i < NUM_COEFS; i++) coef_sh[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(0, 0, 112);
        test_random(47, 0, 112);
        test_random(0, 47, 112);
        test_random(25, 25, 112);

        if (pending_elements.size() > 0)
        begin
            $error("element: %0d expected results never arrived",
                   pending_elements.size());
            errors++;
        end
        if (errors == 0)
            $display("wigner_small_d_evaluator_tb OK");
        else
            $display("wigner_small_d_evaluator_tb NOT OK");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("wigner_small_d_evaluator_tb NOT OK");
        $finish;
    end

endmodule
